### src/scf_pkg.sv
// shared types and constants for the stereo crossfeed fir scaler
`default_nettype none
package scf_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 32;
  localparam int LEVEL_W     = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int FIR_SHIFT   = 31;
  localparam int LEVEL_SHIFT = 15;
  // scaled channel: sample times unsigned level, then shifted
  localparam int SCALED_W    = SAMPLE_W + LEVEL_W + 1 - LEVEL_SHIFT;

  localparam logic [1:0] CMD_PROCESS = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [1:0] REG_MONO_ENABLE   = 2'd1;
  localparam logic [1:0] REG_LEVEL_LEFT    = 2'd2;
  localparam logic [1:0] REG_LEVEL_RIGHT   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIR_WAIT,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_SCALE_WAIT,
    ST_FIN
  } state_t;

  // tag travelling alongside each multiply
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic chan;
    logic scale;
  } mac_tag_t;

  typedef struct packed {
    logic vld;
    logic chan;
    logic scale;
  } mac_res_t;

  typedef struct packed {
    logic shift_in;
    logic clear;
    logic rot_left;
    logic rot_right;
  } dl_ctl_t;

endpackage
`default_nettype wire

### src/scf_coef_ram.sv
// coefficient store, one write port and one registered read port
`default_nettype none
module scf_coef_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [AW-1:0]                     wr_addr,
  input  wire logic signed [scf_pkg::COEF_W-1:0] wr_data,
  input  wire logic [AW-1:0]                     rd_addr,
  output logic signed [scf_pkg::COEF_W-1:0]      rd_data
);
  import scf_pkg::*;

  logic signed [COEF_W-1:0] mem_r [DEPTH];
  logic signed [COEF_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### src/scf_delay_line.sv
// left and right sample delay lines, rotated so the current tap sits at position zero
`default_nettype none
module scf_delay_line #(
  parameter int TAP_COUNT = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire scf_pkg::dl_ctl_t                    ctl,
  input  wire logic signed [scf_pkg::SAMPLE_W-1:0] sample_left,
  input  wire logic signed [scf_pkg::SAMPLE_W-1:0] sample_right,
  output logic signed [scf_pkg::SAMPLE_W-1:0]      tap_left,
  output logic signed [scf_pkg::SAMPLE_W-1:0]      tap_right
);
  import scf_pkg::*;

  logic signed [SAMPLE_W-1:0] dl_left_r  [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] dl_right_r [TAP_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        dl_left_r[i]  <= '0;
        dl_right_r[i] <= '0;
      end
    end else if (ctl.shift_in) begin
      for (int i = TAP_COUNT - 1; i > 0; i--) begin
        dl_left_r[i]  <= dl_left_r[i-1];
        dl_right_r[i] <= dl_right_r[i-1];
      end
      dl_left_r[0]  <= sample_left;
      dl_right_r[0] <= sample_right;
    end else begin
      // full rotation over one pass brings the line back in place
      if (ctl.rot_left) begin
        for (int i = 0; i < TAP_COUNT - 1; i++) begin
          dl_left_r[i] <= dl_left_r[i+1];
        end
        dl_left_r[TAP_COUNT-1] <= dl_left_r[0];
      end
      if (ctl.rot_right) begin
        for (int i = 0; i < TAP_COUNT - 1; i++) begin
          dl_right_r[i] <= dl_right_r[i+1];
        end
        dl_right_r[TAP_COUNT-1] <= dl_right_r[0];
      end
    end
  end

  assign tap_left  = dl_left_r[0];
  assign tap_right = dl_right_r[0];

endmodule
`default_nettype wire

### src/scf_mac.sv
// shared multiply-accumulate unit: operand stage, product stage, accumulator
`default_nettype none
module scf_mac #(
  parameter int TAP_COUNT = 32,
  localparam int ACC_W = scf_pkg::PROD_W + $clog2(2 * TAP_COUNT)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire scf_pkg::mac_tag_t                   tag,
  input  wire logic signed [scf_pkg::SAMPLE_W-1:0] op_a,
  input  wire logic signed [scf_pkg::COEF_W-1:0]   op_imm,
  input  wire logic signed [scf_pkg::COEF_W-1:0]   coef_rdata,
  output scf_pkg::mac_res_t                        res,
  output logic signed [ACC_W-1:0]                  res_val
);
  import scf_pkg::*;

  mac_tag_t                 tag1_r;
  mac_tag_t                 tag2_r;
  mac_res_t                 res_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [COEF_W-1:0]   imm_r;
  logic signed [COEF_W-1:0]   op_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    res_val_r;

  // coefficient arrives from the ram in the cycle after issue, alongside the registered operands
  assign op_b     = tag1_r.scale ? imm_r : coef_rdata;
  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = tag2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      res_r  <= '0;
    end else begin
      tag1_r    <= tag;
      tag2_r    <= tag1_r;
      res_r.vld   <= tag2_r.vld && tag2_r.last;
      res_r.chan  <= tag2_r.chan;
      res_r.scale <= tag2_r.scale;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= op_a;
    imm_r  <= op_imm;
    prod_r <= a_r * op_b;
    if (tag2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (tag2_r.vld && tag2_r.last) begin
      res_val_r <= acc_nxt;
    end
  end

  assign res     = res_r;
  assign res_val = res_val_r;

endmodule
`default_nettype wire

### src/stereo_crossfeed_fir_scaler_unit.sv
// top level of the stereo crossfeed fir scaler: sequencer, registers and output stage
`default_nettype none
// Stereo crossfeed FIR with per-channel level and optional mono mix. One
// 24x32 signed multiplier with a 62-bit accumulator at 32 taps is shared
// by every product. With the filter on, a process request runs the four FIR
// passes, which issue one tap per cycle through the multiplier, followed by
// the two level multiplies and the three-stage pipeline drain after each
// group. With the filter off only the level multiplies run; a coefficient
// load or a delay-line clear produces no result. The finished pair sits in
// an output register, so the next request is taken while it waits for
// out_ready; a pair that finishes while the previous one still waits holds
// the block in its final cycle until out_ready. No clearing pass runs after
// reset; coefficients read back undefined until loaded.
module stereo_crossfeed_fir_scaler_unit #(
  parameter int TAP_COUNT = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic signed [scf_pkg::SAMPLE_W-1:0] in_sample_left,
  input  wire logic signed [scf_pkg::SAMPLE_W-1:0] in_sample_right,
  input  wire logic [6:0]                          in_coef_index,
  input  wire logic signed [scf_pkg::COEF_W-1:0]   in_coef_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [scf_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [scf_pkg::SAMPLE_W-1:0]      out_right,
  // configuration
  input  wire logic                                cfg_write_en,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [scf_pkg::LEVEL_W-1:0]         cfg_data
);
  import scf_pkg::*;

  localparam int COEF_DEPTH = 4 * TAP_COUNT;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int TAP_W      = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ACC_W      = PROD_W + $clog2(2 * TAP_COUNT);
  // coefficient set bases in pass order: left direct, right-to-left cross,
  // right direct, left-to-right cross
  localparam logic [CA_W-1:0] BASE_LD = CA_W'(0);
  localparam logic [CA_W-1:0] BASE_RD = CA_W'(TAP_COUNT);
  localparam logic [CA_W-1:0] BASE_LX = CA_W'(2 * TAP_COUNT);
  localparam logic [CA_W-1:0] BASE_RX = CA_W'(3 * TAP_COUNT);
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

  // configuration registers
  logic                filter_en_r;
  logic                mono_en_r;
  logic [LEVEL_W-1:0]  level_left_r;
  logic [LEVEL_W-1:0]  level_right_r;

  state_t              state_r;
  state_t              state_nxt;
  logic [TAP_W-1:0]    tap_cnt_r;
  logic [1:0]          pass_r;

  // working values: input pair / fir result, then scaled channels
  logic signed [SAMPLE_W-1:0] fir_left_r;
  logic signed [SAMPLE_W-1:0] fir_right_r;
  logic signed [SCALED_W-1:0] gain_left_r;
  logic signed [SCALED_W-1:0] gain_right_r;
  logic signed [SCALED_W:0]   mono_sum;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;

  logic                       accept;
  logic                       tap_end;
  logic                       coef_we;
  logic [CA_W-1:0]            coef_rd_addr;
  logic [CA_W-1:0]            coef_base;
  logic signed [COEF_W-1:0]   coef_rdata;
  logic signed [SAMPLE_W-1:0] tap_left;
  logic signed [SAMPLE_W-1:0] tap_right;
  dl_ctl_t                    dl_ctl;
  mac_tag_t                   mac_tag;
  mac_res_t                   mac_res;
  logic signed [SAMPLE_W-1:0] mac_a;
  logic signed [COEF_W-1:0]   mac_imm;
  logic signed [ACC_W-1:0]    mac_val;
  logic                       out_free;

  assign accept   = in_valid && in_ready;
  assign tap_end  = (tap_cnt_r == TAP_LAST);
  assign out_free = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r   <= 1'b0;
      mono_en_r     <= 1'b0;
      level_left_r  <= '0;
      level_right_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FILTER_ENABLE: filter_en_r   <= cfg_data[0];
        REG_MONO_ENABLE:   mono_en_r     <= cfg_data[0];
        REG_LEVEL_LEFT:    level_left_r  <= cfg_data;
        REG_LEVEL_RIGHT:   level_right_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_PROCESS) begin
          state_nxt = filter_en_r ? ST_MAC : ST_SCALE_L;
        end
      end
      ST_MAC: begin
        if (tap_end && pass_r == 2'd3) begin
          state_nxt = ST_FIR_WAIT;
        end
      end
      ST_FIR_WAIT: begin
        // right-channel fir sum is the final one to come back
        if (mac_res.vld && !mac_res.scale && mac_res.chan) begin
          state_nxt = ST_SCALE_L;
        end
      end
      ST_SCALE_L: state_nxt = ST_SCALE_R;
      ST_SCALE_R: state_nxt = ST_SCALE_WAIT;
      ST_SCALE_WAIT: begin
        if (mac_res.vld && mac_res.scale && mac_res.chan) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // set base for the current pass
  always_comb begin
    unique case (pass_r)
      2'd0:    coef_base = BASE_LD;
      2'd1:    coef_base = BASE_RX;
      2'd2:    coef_base = BASE_RD;
      2'd3:    coef_base = BASE_LX;
      default: coef_base = BASE_LD;
    endcase
  end

  assign coef_rd_addr = coef_base + CA_W'(tap_cnt_r);

  // control outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    coef_we  = 1'b0;
    dl_ctl   = '0;
    mac_tag  = '0;
    mac_a    = tap_left;
    mac_imm  = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          coef_we         = (in_cmd == CMD_LOAD) && (32'(in_coef_index) < 32'(COEF_DEPTH));
          dl_ctl.clear    = (in_cmd == CMD_CLEAR);
          dl_ctl.shift_in = (in_cmd == CMD_PROCESS) && filter_en_r;
        end
      end
      ST_MAC: begin
        // passes 0 and 1 build the left sum, passes 2 and 3 the right sum
        mac_tag.vld   = 1'b1;
        mac_tag.first = (tap_cnt_r == '0) && !pass_r[0];
        mac_tag.last  = tap_end && pass_r[0];
        mac_tag.chan  = pass_r[1];
        mac_tag.scale = 1'b0;
        // left line feeds passes 0 and 3, right line passes 1 and 2
        if (pass_r[0] ^ pass_r[1]) begin
          mac_a            = tap_right;
          dl_ctl.rot_right = 1'b1;
        end else begin
          mac_a           = tap_left;
          dl_ctl.rot_left = 1'b1;
        end
      end
      ST_SCALE_L: begin
        mac_tag = '{vld: 1'b1, first: 1'b1, last: 1'b1, chan: 1'b0, scale: 1'b1};
        mac_a   = fir_left_r;
        mac_imm = COEF_W'(level_left_r);
      end
      ST_SCALE_R: begin
        mac_tag = '{vld: 1'b1, first: 1'b1, last: 1'b1, chan: 1'b1, scale: 1'b1};
        mac_a   = fir_right_r;
        mac_imm = COEF_W'(level_right_r);
      end
      ST_FIR_WAIT, ST_SCALE_WAIT, ST_FIN: ;
      default: ;
    endcase
  end

  // state and tap/pass counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tap_cnt_r <= '0;
      pass_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MAC) begin
        if (tap_end) begin
          tap_cnt_r <= '0;
          pass_r    <= pass_r + 2'd1;
        end else begin
          tap_cnt_r <= tap_cnt_r + TAP_W'(1);
        end
      end else begin
        tap_cnt_r <= '0;
        pass_r    <= '0;
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_PROCESS) begin
      // bypass path scales the input pair directly
      fir_left_r  <= in_sample_left;
      fir_right_r <= in_sample_right;
    end else if (mac_res.vld && !mac_res.scale) begin
      if (mac_res.chan) begin
        fir_right_r <= mac_val[FIR_SHIFT +: SAMPLE_W];
      end else begin
        fir_left_r  <= mac_val[FIR_SHIFT +: SAMPLE_W];
      end
    end
    if (mac_res.vld && mac_res.scale) begin
      if (mac_res.chan) begin
        gain_right_r <= mac_val[LEVEL_SHIFT +: SCALED_W];
      end else begin
        gain_left_r  <= mac_val[LEVEL_SHIFT +: SCALED_W];
      end
    end
  end

  // mono mix: exact sum, halved with floor
  assign mono_sum = {gain_left_r[SCALED_W-1], gain_left_r}
                  + {gain_right_r[SCALED_W-1], gain_right_r};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      if (mono_en_r) begin
        out_left_r  <= mono_sum[SAMPLE_W:1];
        out_right_r <= mono_sum[SAMPLE_W:1];
      end else begin
        out_left_r  <= gain_left_r[SAMPLE_W-1:0];
        out_right_r <= gain_right_r[SAMPLE_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  scf_coef_ram #(
    .DEPTH (COEF_DEPTH),
    .AW    (CA_W)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (CA_W'(in_coef_index)),
    .wr_data (in_coef_value),
    .rd_addr (coef_rd_addr),
    .rd_data (coef_rdata)
  );

  scf_delay_line #(
    .TAP_COUNT (TAP_COUNT)
  ) u_delay_line (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (dl_ctl),
    .sample_left  (in_sample_left),
    .sample_right (in_sample_right),
    .tap_left     (tap_left),
    .tap_right    (tap_right)
  );

  scf_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (mac_tag),
    .op_a       (mac_a),
    .op_imm     (mac_imm),
    .coef_rdata (coef_rdata),
    .res        (mac_res),
    .res_val    (mac_val)
  );

endmodule
`default_nettype wire
